// ===== rtl/tcprc_pkg.sv =====
`timescale 1ns / 1ps

package tcprc_pkg;

  localparam int unsigned SeqW = 32;
  localparam int unsigned LenW = 16;

  typedef enum logic [2:0] {
    VERDICT_ACCEPTED    = 3'd0,
    VERDICT_UNACCEPT    = 3'd1,
    VERDICT_NOT_CHECKED = 3'd2,
    VERDICT_PROBE       = 3'd3,
    VERDICT_HOLE        = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    WAKE_NONE    = 2'd0,
    WAKE_READERS = 2'd1,
    WAKE_CLOSE   = 2'd2
  } wake_e;

  typedef enum logic {
    FUNC_PROCESS = 1'b0,
    FUNC_LOAD    = 1'b1
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [SeqW-1:0]   seq_number;
    logic [LenW-1:0]   payload_length;
    logic              syn_flag;
    logic              fin_flag;
    logic              rst_flag;
    logic              synchronized;
    logic [LenW-1:0]   receive_window_free;
  } seg_t;

  typedef struct packed {
    verdict_e          verdict;
    logic              send_ack;
    logic              keepalive_seen;
    logic [LenW-1:0]   copy_offset;
    logic [LenW-1:0]   copy_count;
    logic              fin_taken;
    wake_e             wake_reader;
    logic [SeqW-1:0]   next_expected_out;
  } res_t;

  function automatic logic seq_lt(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
    logic [SeqW-1:0] d;
    d = a - b;
    return d[SeqW-1];
  endfunction

  function automatic logic seq_le(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
    return (a == b) || seq_lt(a, b);
  endfunction

endpackage

// ===== rtl/tcprc_check.sv =====
`timescale 1ns / 1ps

module tcprc_check (
  input  tcprc_pkg::seg_t                  seg_i,
  input  logic [tcprc_pkg::SeqW-1:0]       next_expected_i,
  input  logic                             fin_received_i,
  output tcprc_pkg::res_t                  res_o,
  output logic [tcprc_pkg::SeqW-1:0]       next_expected_o,
  output logic                             fin_received_o
);

  localparam int unsigned SeqW = tcprc_pkg::SeqW;
  localparam int unsigned LenW = tcprc_pkg::LenW;

  logic [LenW:0]   slen;
  logic [SeqW-1:0] ne;
  logic [SeqW-1:0] seq;
  logic [SeqW-1:0] wlast;
  logic [SeqW-1:0] slast;
  logic [SeqW-1:0] rlast;
  logic [SeqW-1:0] tail;
  logic [SeqW-1:0] head;
  logic            tail_trim;
  logic            head_trim;
  logic [LenW-1:0] plen;
  logic [LenW-1:0] dlen_tail;
  logic [LenW-1:0] dlen;
  logic            win_zero;
  logic            seq_hit;
  logic            ok;
  logic            fin_kept;
  logic            hole;
  logic            first_in;
  logic            last_in;

  assign ne       = next_expected_i;
  assign seq      = seg_i.seq_number;
  assign plen     = seg_i.payload_length;
  assign slen     = (LenW+1)'(plen) + (LenW+1)'(seg_i.syn_flag) + (LenW+1)'(seg_i.fin_flag);
  assign wlast    = ne + SeqW'(seg_i.receive_window_free) - SeqW'(1);
  assign slast    = seq + SeqW'(slen) - SeqW'(1);
  assign rlast    = seq + SeqW'(plen) - SeqW'(1);
  assign win_zero = (seg_i.receive_window_free == '0);
  assign seq_hit  = (seq == ne);

  assign first_in = tcprc_pkg::seq_le(ne, seq) && tcprc_pkg::seq_le(seq, wlast);
  assign last_in  = tcprc_pkg::seq_le(ne, slast) && tcprc_pkg::seq_le(slast, wlast);

  always_comb begin
    if (win_zero) begin
      ok = (slen == '0) && seq_hit;
    end else if (slen == '0) begin
      ok = first_in;
    end else begin
      ok = first_in || last_in;
    end
  end

  // tail trim to the window, then head trim to next expected
  assign tail_trim = tcprc_pkg::seq_lt(wlast, rlast);
  assign tail      = rlast - wlast;
  assign head_trim = tcprc_pkg::seq_lt(seq, ne);
  assign head      = ne - seq;

  always_comb begin
    dlen_tail = plen;
    if (tail_trim) begin
      if ((tail[SeqW-1:LenW] != '0) || (tail[LenW-1:0] >= plen)) begin
        dlen_tail = '0;
      end else begin
        dlen_tail = plen - tail[LenW-1:0];
      end
    end
    dlen = dlen_tail;
    if (head_trim) begin
      if ((head[SeqW-1:LenW] != '0) || (head[LenW-1:0] >= dlen_tail)) begin
        dlen = '0;
      end else begin
        dlen = dlen_tail - head[LenW-1:0];
      end
    end
  end

  assign fin_kept = seg_i.fin_flag && !tail_trim;
  assign hole     = !head_trim && !seq_hit;

  always_comb begin
    res_o                   = '0;
    res_o.verdict           = tcprc_pkg::VERDICT_NOT_CHECKED;
    res_o.wake_reader       = tcprc_pkg::WAKE_NONE;
    next_expected_o         = ne;
    fin_received_o          = fin_received_i;
    if (seg_i.func == tcprc_pkg::FUNC_LOAD) begin
      next_expected_o = seq;
      fin_received_o  = 1'b0;
    end else if (seg_i.synchronized) begin
      if (seq_hit && (plen == LenW'(1)) && win_zero) begin
        res_o.verdict  = tcprc_pkg::VERDICT_PROBE;
        res_o.send_ack = 1'b1;
      end else if (!ok) begin
        res_o.verdict        = tcprc_pkg::VERDICT_UNACCEPT;
        res_o.send_ack       = !seg_i.rst_flag;
        res_o.keepalive_seen = (seq == (ne - SeqW'(1)));
      end else if (hole) begin
        res_o.verdict  = tcprc_pkg::VERDICT_HOLE;
        res_o.send_ack = 1'b1;
      end else begin
        res_o.verdict = tcprc_pkg::VERDICT_ACCEPTED;
        if (dlen != '0) begin
          res_o.copy_count  = dlen;
          res_o.copy_offset = head_trim ? head[LenW-1:0] : '0;
        end
        next_expected_o = ne + SeqW'(dlen) + SeqW'(fin_kept);
        if (fin_kept) begin
          fin_received_o  = 1'b1;
          res_o.fin_taken = 1'b1;
        end
        if ((dlen != '0) || fin_kept) begin
          res_o.send_ack    = 1'b1;
          res_o.wake_reader = (fin_kept || fin_received_i) ? tcprc_pkg::WAKE_CLOSE
                                                           : tcprc_pkg::WAKE_READERS;
        end
      end
    end
    res_o.next_expected_out = next_expected_o;
  end

endmodule

// ===== rtl/tcp_receive_sequence_check_trim.sv =====
`timescale 1ns / 1ps
// an accepted input word is registered, then its result word; throughput: one
// segment header per cycle if not stalled, set by the single check stage that
// reads and updates next expected sequence and fin received in the same cycle
// reset: asynchronous active low, clears both stage valids, next expected and
// fin received to zero

module tcp_receive_sequence_check_trim (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // seq_number[31:0], payload_length[47:32], syn_flag[48], fin_flag[49],
  // rst_flag[50], synchronized[51], receive_window_free[67:52], zero pad
  input  logic [71:0] s_axis_tdata,
  // func[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // send_ack[0], keepalive_seen[1], copy_offset[17:2], copy_count[33:18],
  // fin_taken[34], wake_reader[36:35], next_expected_out[68:37], zero pad
  output logic [71:0] m_axis_tdata,
  // verdict[2:0]
  output logic [2:0]  m_axis_tuser
);

  localparam int unsigned SeqW = tcprc_pkg::SeqW;

  tcprc_pkg::seg_t in_d;
  tcprc_pkg::seg_t in_q;
  logic            in_valid_q;
  tcprc_pkg::res_t res_d;
  tcprc_pkg::res_t res_q;
  logic            res_valid_q;
  logic [SeqW-1:0] next_expected_d;
  logic [SeqW-1:0] next_expected_q;
  logic            fin_received_d;
  logic            fin_received_q;
  logic            advance;
  logic            in_take;

  assign advance       = in_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_d                     = '0;
    in_d.func                = tcprc_pkg::func_e'(s_axis_tuser);
    in_d.seq_number          = s_axis_tdata[31:0];
    in_d.payload_length      = s_axis_tdata[47:32];
    in_d.syn_flag            = s_axis_tdata[48];
    in_d.fin_flag            = s_axis_tdata[49];
    in_d.rst_flag            = s_axis_tdata[50];
    in_d.synchronized        = s_axis_tdata[51];
    in_d.receive_window_free = s_axis_tdata[67:52];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_d;
    end
  end

  tcprc_check u_check (
    .seg_i           (in_q),
    .next_expected_i (next_expected_q),
    .fin_received_i  (fin_received_q),
    .res_o           (res_d),
    .next_expected_o (next_expected_d),
    .fin_received_o  (fin_received_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_expected_q <= '0;
      fin_received_q  <= 1'b0;
      res_valid_q     <= 1'b0;
    end else begin
      if (advance) begin
        next_expected_q <= next_expected_d;
        fin_received_q  <= fin_received_d;
        res_valid_q     <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tuser  = res_q.verdict;
  assign m_axis_tdata  = {3'b000,
                          res_q.next_expected_out,
                          res_q.wake_reader,
                          res_q.fin_taken,
                          res_q.copy_count,
                          res_q.copy_offset,
                          res_q.keepalive_seen,
                          res_q.send_ack};

`ifndef ASSERT_OFF
  a_load_sets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_q.func == tcprc_pkg::FUNC_LOAD)) |=>
      ((next_expected_q == $past(in_q.seq_number)) && !fin_received_q))
    else $error("load did not set next expected sequence");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input not ready while check stage empty");

  a_copy_only_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res_q.verdict != tcprc_pkg::VERDICT_ACCEPTED)) |->
      ((res_q.copy_count == '0) && !res_q.fin_taken &&
       (res_q.wake_reader == tcprc_pkg::WAKE_NONE)))
    else $error("copy or wake on a segment that was not accepted");

  a_fin_wakes_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.fin_taken) |=>
      (fin_received_q && (res_q.wake_reader == tcprc_pkg::WAKE_CLOSE)))
    else $error("fin taken without close wake");
`endif

endmodule
